### src/bpc_pkg.sv
// Shared types and constants for the burn phase controller.
// Holds the command and phase codes, register indexes and timing constants.
// No dependencies.
`default_nettype none

package bpc_pkg;

    // Input commands.
    typedef enum logic [2:0] {
        CMD_SAMPLE       = 3'd0,
        CMD_INIT         = 3'd1,
        CMD_START_BOOST  = 3'd2,
        CMD_FORCE_SAFETY = 3'd3,
        CMD_FORCE_IDLE   = 3'd4
    } cmd_t;

    // Burn phases, as reported on the result channel.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BOOST   = 3'd1,
        PH_RAMP    = 3'd2,
        PH_HOLD    = 3'd3,
        PH_COALBED = 3'd4,
        PH_SAFETY  = 3'd5
    } phase_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_EXHAUST_SETPOINT = 3'd0;
    localparam logic [2:0] REG_DEADBAND         = 3'd1;
    localparam logic [2:0] REG_BOOST_SECONDS    = 3'd2;
    localparam logic [2:0] REG_FLUE_LOW_LIMIT   = 3'd3;
    localparam logic [2:0] REG_COALBED_MINUTES  = 3'd4;
    localparam logic [2:0] REG_FAN_FLOOR        = 3'd5;
    localparam logic [2:0] REG_FAN_CEILING      = 3'd6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    // Timing constants in milliseconds.
    localparam logic [31:0] HOLD_STABLE_MS = 32'd5000;
    localparam logic [31:0] RAMP_STABLE_MS = 32'd3000;
    localparam logic [31:0] MS_PER_SEC     = 32'd1000;
    localparam logic [31:0] MS_PER_MIN     = 32'd60000;

    // Fan curve constants (error in 1/16 degree, fan in percent).
    localparam logic [6:0] FAN_FULL        = 7'd100;
    localparam logic [6:0] FAN_SOFT_CAP    = 7'd80;
    localparam logic [6:0] FAN_ZONE3_BASE  = 7'd50;
    localparam logic [6:0] FAN_CEILING_RST = 7'd100;
    localparam int         ERR_ZONE1       = 80;
    localparam int         ERR_ZONE2       = 400;
    localparam int         ERR_ZONE3_CAP   = 640;

endpackage

`default_nettype wire

### src/burn_phase_controller.sv
// Burn phase controller top level: configuration registers, phase state and
// the registered result stage. Depends on bpc_pkg.
//
// The block takes one item per clock unless stalled. Every item yields
// exactly one result, which appears in the output register on the cycle
// after the item is accepted. The phase step (timer compares on wrapping
// 32-bit differences, temperature thresholds and the hold fan curve) is
// one pass of logic from the input ports and the state registers into the
// output register, so s_ready stays high while the output register is
// empty or being drained; it drops only while a result waits and m_ready
// is low. Configuration writes take effect at the edge where cfg_we is
// high and apply to items accepted after that edge.
`default_nettype none

module burn_phase_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [bpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input item channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_cmd,
    input  wire logic [31:0]                       s_now_ms,
    input  wire logic signed [15:0]                s_exhaust_temp,
    // Result item channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [6:0]                             m_fan_percent,
    output logic                                   m_damper_open,
    output logic [2:0]                             m_phase,
    output logic                                   m_boost_on
);

    // Configuration registers.
    logic [10:0] exhaust_setpoint_reg;
    logic [7:0]  deadband_reg;
    logic [14:0] boost_seconds_reg;
    logic [10:0] flue_low_limit_reg;
    logic [14:0] coalbed_minutes_reg;
    logic [6:0]  fan_floor_reg;
    logic [6:0]  fan_ceiling_reg;

    // Phase state.
    bpc_pkg::phase_t phase_reg, phase_next;
    logic        boost_running_reg, boost_running_next;
    logic [31:0] boost_start_reg, boost_start_next;
    logic        coalbed_running_reg, coalbed_running_next;
    logic [31:0] coalbed_start_reg, coalbed_start_next;
    logic        hold_running_reg, hold_running_next;
    logic [31:0] hold_start_reg, hold_start_next;
    logic        ramp_running_reg, ramp_running_next;
    logic [31:0] ramp_start_reg, ramp_start_next;
    logic        damper_reg, damper_next;

    // Result register.
    logic        m_valid_reg;
    logic [6:0]  fan_reg, fan_next;

    logic        in_accept;

    // Derived thresholds.
    logic [31:0]        boost_ms;
    logic [31:0]        coalbed_ms;
    logic signed [17:0] temp_x;
    logic signed [17:0] sp_x;
    logic signed [17:0] db_x;
    logic signed [17:0] flue_thr;
    logic signed [17:0] hold_thr;
    logic signed [17:0] ramp_thr;
    logic signed [17:0] sp_thr;
    logic signed [17:0] err;

    // Hold fan curve: three zones on the error below setpoint, soft cap, clamp.
    function automatic logic [6:0] hold_fan(
        input logic signed [17:0] e,
        input logic [6:0]         lo,
        input logic [6:0]         hi
    );
        logic signed [18:0] fan;
        logic signed [18:0] lo_s;
        logic signed [18:0] hi_s;
        logic signed [18:0] cap_s;
        logic [6:0]         res;
        lo_s  = $signed({12'd0, lo});
        cap_s = $signed({12'd0, bpc_pkg::FAN_SOFT_CAP});
        if (e <= 18'(bpc_pkg::ERR_ZONE1)) begin
            res = lo;
        end else if (e <= 18'(bpc_pkg::ERR_ZONE2)) begin
            hi_s = $signed({12'd0, hi});
            fan  = lo_s + 19'((e - 18'(bpc_pkg::ERR_ZONE1)) >>> 3);
            if (fan > cap_s) begin
                fan = cap_s;
            end
            if (fan < lo_s) begin
                res = lo;
            end else if (fan > hi_s) begin
                res = hi;
            end else begin
                res = fan[6:0];
            end
        end else begin
            hi_s = $signed({12'd0, bpc_pkg::FAN_FULL});
            fan  = $signed({12'd0, bpc_pkg::FAN_ZONE3_BASE})
                 + 19'((e - 18'(bpc_pkg::ERR_ZONE2)) >>> 3);
            if (e <= 18'(bpc_pkg::ERR_ZONE3_CAP) && fan > cap_s) begin
                fan = cap_s;
            end
            if (fan < lo_s) begin
                res = lo;
            end else if (fan > hi_s) begin
                res = bpc_pkg::FAN_FULL;
            end else begin
                res = fan[6:0];
            end
        end
        return res;
    endfunction

    // Handshake: take an item whenever the result register is free or draining.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Timer lengths and temperature thresholds in 1/16 degree.
    assign boost_ms   = 32'(boost_seconds_reg) * bpc_pkg::MS_PER_SEC;
    assign coalbed_ms = 32'(coalbed_minutes_reg) * bpc_pkg::MS_PER_MIN;
    assign temp_x     = 18'(s_exhaust_temp);
    assign sp_x       = $signed({7'd0, exhaust_setpoint_reg});
    assign db_x       = $signed({10'd0, deadband_reg});
    assign flue_thr   = $signed({7'd0, flue_low_limit_reg}) <<< 4;
    assign hold_thr   = (sp_x - db_x) <<< 4;
    assign ramp_thr   = (sp_x - (db_x <<< 1)) <<< 4;
    assign sp_thr     = sp_x <<< 4;
    assign err        = sp_thr - temp_x;

    // Next state of the phase machine for the item at the input.
    always_comb begin
        logic boost_hold;
        phase_next           = phase_reg;
        boost_running_next   = boost_running_reg;
        boost_start_next     = boost_start_reg;
        coalbed_running_next = coalbed_running_reg;
        coalbed_start_next   = coalbed_start_reg;
        hold_running_next    = hold_running_reg;
        hold_start_next      = hold_start_reg;
        ramp_running_next    = ramp_running_reg;
        ramp_start_next      = ramp_start_reg;
        damper_next          = damper_reg;
        boost_hold           = 1'b0;

        case (s_cmd)
            bpc_pkg::CMD_SAMPLE: begin
                if (phase_reg == bpc_pkg::PH_SAFETY) begin
                    // Safety drops every timer and closes the damper.
                    boost_running_next   = 1'b0;
                    coalbed_running_next = 1'b0;
                    hold_running_next    = 1'b0;
                    ramp_running_next    = 1'b0;
                    damper_next          = 1'b0;
                end else begin
                    // Boost countdown.
                    if (boost_running_reg) begin
                        if (s_now_ms - boost_start_reg < boost_ms) begin
                            phase_next  = bpc_pkg::PH_BOOST;
                            damper_next = 1'b1;
                            boost_hold  = 1'b1;
                        end else begin
                            boost_running_next = 1'b0;
                            phase_next         = bpc_pkg::PH_RAMP;
                        end
                    end
                    if (!boost_hold) begin
                        // Coal-bed timer runs while the flue is below its limit.
                        if (temp_x < flue_thr) begin
                            if (!coalbed_running_reg) begin
                                coalbed_running_next = 1'b1;
                                coalbed_start_next   = s_now_ms;
                            end
                            if (s_now_ms - coalbed_start_next >= coalbed_ms) begin
                                phase_next           = bpc_pkg::PH_COALBED;
                                coalbed_running_next = 1'b0;
                                hold_running_next    = 1'b0;
                                ramp_running_next    = 1'b0;
                            end
                        end else begin
                            coalbed_running_next = 1'b0;
                        end

                        // Stability timers between ramp and hold.
                        case (phase_next)
                            bpc_pkg::PH_RAMP: begin
                                if (temp_x >= hold_thr) begin
                                    if (!hold_running_next) begin
                                        hold_running_next = 1'b1;
                                        hold_start_next   = s_now_ms;
                                    end
                                    if (s_now_ms - hold_start_next
                                            >= bpc_pkg::HOLD_STABLE_MS) begin
                                        phase_next        = bpc_pkg::PH_HOLD;
                                        hold_running_next = 1'b0;
                                    end
                                end else begin
                                    hold_running_next = 1'b0;
                                end
                            end
                            bpc_pkg::PH_HOLD: begin
                                if (temp_x < ramp_thr) begin
                                    if (!ramp_running_next) begin
                                        ramp_running_next = 1'b1;
                                        ramp_start_next   = s_now_ms;
                                    end
                                    if (s_now_ms - ramp_start_next
                                            >= bpc_pkg::RAMP_STABLE_MS) begin
                                        phase_next        = bpc_pkg::PH_RAMP;
                                        ramp_running_next = 1'b0;
                                        hold_running_next = 1'b0;
                                    end
                                end else begin
                                    ramp_running_next = 1'b0;
                                end
                            end
                            bpc_pkg::PH_COALBED: begin
                                if (temp_x > hold_thr) begin
                                    phase_next        = bpc_pkg::PH_RAMP;
                                    hold_running_next = 1'b0;
                                    ramp_running_next = 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase

                        damper_next = (phase_next != bpc_pkg::PH_IDLE);
                    end
                end
            end
            bpc_pkg::CMD_INIT: begin
                phase_next           = bpc_pkg::PH_BOOST;
                boost_running_next   = 1'b1;
                boost_start_next     = s_now_ms;
                hold_running_next    = 1'b0;
                ramp_running_next    = 1'b0;
                coalbed_running_next = 1'b0;
                damper_next          = 1'b0;
            end
            bpc_pkg::CMD_START_BOOST: begin
                if (phase_reg != bpc_pkg::PH_SAFETY) begin
                    boost_running_next = 1'b1;
                    boost_start_next   = s_now_ms;
                    phase_next         = bpc_pkg::PH_BOOST;
                end
            end
            bpc_pkg::CMD_FORCE_SAFETY: begin
                phase_next = bpc_pkg::PH_SAFETY;
            end
            bpc_pkg::CMD_FORCE_IDLE: begin
                phase_next = bpc_pkg::PH_IDLE;
            end
            default: begin
            end
        endcase
    end

    // Fan demand for the item: only a sample command drives the fan.
    always_comb begin
        fan_next = '0;
        if (s_cmd == bpc_pkg::CMD_SAMPLE) begin
            case (phase_next)
                bpc_pkg::PH_BOOST,
                bpc_pkg::PH_RAMP:  fan_next = bpc_pkg::FAN_FULL;
                bpc_pkg::PH_HOLD:  fan_next = hold_fan(err, fan_floor_reg, fan_ceiling_reg);
                default:           fan_next = '0;
            endcase
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exhaust_setpoint_reg <= '0;
            deadband_reg         <= '0;
            boost_seconds_reg    <= '0;
            flue_low_limit_reg   <= '0;
            coalbed_minutes_reg  <= '0;
            fan_floor_reg        <= '0;
            fan_ceiling_reg      <= bpc_pkg::FAN_CEILING_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                bpc_pkg::REG_EXHAUST_SETPOINT: exhaust_setpoint_reg <= cfg_wdata[10:0];
                bpc_pkg::REG_DEADBAND:         deadband_reg         <= cfg_wdata[7:0];
                bpc_pkg::REG_BOOST_SECONDS:    boost_seconds_reg    <= cfg_wdata[14:0];
                bpc_pkg::REG_FLUE_LOW_LIMIT:   flue_low_limit_reg   <= cfg_wdata[10:0];
                bpc_pkg::REG_COALBED_MINUTES:  coalbed_minutes_reg  <= cfg_wdata[14:0];
                bpc_pkg::REG_FAN_FLOOR:        fan_floor_reg        <= cfg_wdata[6:0];
                bpc_pkg::REG_FAN_CEILING:      fan_ceiling_reg      <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Phase state advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= bpc_pkg::PH_IDLE;
            boost_running_reg   <= 1'b0;
            boost_start_reg     <= '0;
            coalbed_running_reg <= 1'b0;
            coalbed_start_reg   <= '0;
            hold_running_reg    <= 1'b0;
            hold_start_reg      <= '0;
            ramp_running_reg    <= 1'b0;
            ramp_start_reg      <= '0;
            damper_reg          <= 1'b0;
        end else if (in_accept) begin
            phase_reg           <= phase_next;
            boost_running_reg   <= boost_running_next;
            boost_start_reg     <= boost_start_next;
            coalbed_running_reg <= coalbed_running_next;
            coalbed_start_reg   <= coalbed_start_next;
            hold_running_reg    <= hold_running_next;
            hold_start_reg      <= hold_start_next;
            ramp_running_reg    <= ramp_running_next;
            ramp_start_reg      <= ramp_start_next;
            damper_reg          <= damper_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; damper, phase and boost flag come from the state registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            fan_reg <= fan_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fan_percent = fan_reg;
    assign m_damper_open = damper_reg;
    assign m_phase       = phase_reg;
    assign m_boost_on    = boost_running_reg;

    // The reported phase always matches the phase state while a result waits.
    a_phase_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_phase == phase_reg))
        else $error("reported phase differs from phase state");

    // Phase state only moves when an item is taken.
    a_state_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> ($stable(phase_reg) && $stable(boost_running_reg)
                        && $stable(damper_reg)))
        else $error("phase state changed without an item");

    // Commands other than sample never drive the fan.
    a_fan_off_for_commands: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_cmd != bpc_pkg::CMD_SAMPLE) |=> (m_fan_percent == '0))
        else $error("fan demand on a non-sample command");

    // A sample in safety stops the fan, closes the damper and stops boost.
    a_safety_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_cmd == bpc_pkg::CMD_SAMPLE && phase_reg == bpc_pkg::PH_SAFETY)
        |=> (m_fan_percent == '0 && !m_damper_open && !m_boost_on
             && phase_reg == bpc_pkg::PH_SAFETY))
        else $error("safety sample left fan, damper or boost active");

    // Init always lands in boost with the damper closed.
    a_init_enters_boost: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_cmd == bpc_pkg::CMD_INIT)
        |=> (phase_reg == bpc_pkg::PH_BOOST && boost_running_reg && !damper_reg))
        else $error("init did not enter boost");

endmodule

`default_nettype wire

### sim/burn_phase_controller_test.sv
// Self-checking testbench for burn_phase_controller: directed rows, then random burn sessions
// under several register settings; results held to typed rows or a cycle-free predictor.
// Depends on bpc_pkg and burn_phase_controller.
module burn_phase_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    // Highest command code; codes above force idle do nothing in the block.
    localparam logic [2:0] CMD_RESERVED = 3'd7;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam int LONG_HOLD_AFTER  = 600;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [6:0] fan;
        logic       damper;
        phase_t     phase;
        logic       boost;
    } burn_status_t;

    typedef struct {
        logic [2:0]   cmd;
        logic [31:0]  now;
        logic [15:0]  temp;
        bit           typed;
        burn_status_t status;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_cmd          = '0;
    logic [31:0]           s_now_ms       = '0;
    logic signed [15:0]    s_exhaust_temp = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [6:0]            m_fan_percent;
    logic                  m_damper_open;
    logic [2:0]            m_phase;
    logic                  m_boost_on;

    // Predictor copy of the registers and the phase state.
    int          cfg_setpoint, cfg_deadband, cfg_boost_s, cfg_flue, cfg_coal_min;
    int          cfg_floor, cfg_ceiling;
    phase_t      cur_phase;
    logic        boost_active, coal_active, settle_active, droop_active, damper_state;
    logic [31:0] boost_t0, coal_t0, settle_t0, droop_t0;

    burn_status_t status_due[$];
    stim_row_t    stim_rows[$];
    int           mismatches = 0;
    int           items_in   = 0;

    burn_phase_controller u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_now_ms       (s_now_ms),
        .s_exhaust_temp (s_exhaust_temp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fan_percent  (m_fan_percent),
        .m_damper_open  (m_damper_open),
        .m_phase        (m_phase),
        .m_boost_on     (m_boost_on)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("burn_phase_controller_test NOT OK");
        $finish;
    end

    function automatic void reset_model();
        cfg_setpoint  = 0;
        cfg_deadband  = 0;
        cfg_boost_s   = 0;
        cfg_flue      = 0;
        cfg_coal_min  = 0;
        cfg_floor     = 0;
        cfg_ceiling   = int'(FAN_CEILING_RST);
        cur_phase     = PH_IDLE;
        boost_active  = 1'b0;
        coal_active   = 1'b0;
        settle_active = 1'b0;
        droop_active  = 1'b0;
        damper_state  = 1'b0;
        boost_t0      = '0;
        coal_t0       = '0;
        settle_t0     = '0;
        droop_t0      = '0;
    endfunction

    // Three-zone fan curve used while holding; error is in 1/16 degree.
    function automatic int hold_fan_demand(int t);
        int err;
        int fan;
        int hi;
        err = cfg_setpoint * 16 - t;
        if (err <= ERR_ZONE1) return cfg_floor;
        if (err <= ERR_ZONE2) begin
            fan = cfg_floor + (err - ERR_ZONE1) / 8;
            if (fan > int'(FAN_SOFT_CAP)) fan = int'(FAN_SOFT_CAP);
            hi = cfg_ceiling;
        end else begin
            fan = int'(FAN_ZONE3_BASE) + (err - ERR_ZONE2) / 8;
            if (err <= ERR_ZONE3_CAP && fan > int'(FAN_SOFT_CAP)) fan = int'(FAN_SOFT_CAP);
            hi = int'(FAN_FULL);
        end
        // The floor test comes first, so a floor above the ceiling wins.
        if (fan < cfg_floor) fan = cfg_floor;
        else if (fan > hi) fan = hi;
        return fan;
    endfunction

    // One sample step of the phase machine; returns the fan demand.
    function automatic int sample_step(logic [31:0] now, int t);
        logic [31:0] span_ms;
        logic [31:0] limit_ms;
        int          sp;
        int          db;
        sp = cfg_setpoint;
        db = cfg_deadband;

        // Safety drops every timer and closes the damper.
        if (cur_phase == PH_SAFETY) begin
            boost_active  = 1'b0;
            coal_active   = 1'b0;
            settle_active = 1'b0;
            droop_active  = 1'b0;
            damper_state  = 1'b0;
            return 0;
        end

        // Boost countdown overrides everything until it runs out.
        if (boost_active) begin
            span_ms  = now - boost_t0;
            limit_ms = cfg_boost_s * MS_PER_SEC;
            if (span_ms < limit_ms) begin
                cur_phase    = PH_BOOST;
                damper_state = 1'b1;
                return int'(FAN_FULL);
            end
            boost_active = 1'b0;
            cur_phase    = PH_RAMP;
        end

        // The coal-bed timer runs in every phase but safety and a running boost while the flue is cold.
        if (t < cfg_flue * 16) begin
            if (!coal_active) begin
                coal_active = 1'b1;
                coal_t0     = now;
            end
            span_ms  = now - coal_t0;
            limit_ms = cfg_coal_min * MS_PER_MIN;
            if (span_ms >= limit_ms) begin
                cur_phase     = PH_COALBED;
                coal_active   = 1'b0;
                settle_active = 1'b0;
                droop_active  = 1'b0;
            end
        end else begin
            coal_active = 1'b0;
        end

        // Ramp, hold and coal-bed transitions.
        if (cur_phase == PH_RAMP) begin
            if (t >= (sp - db) * 16) begin
                if (!settle_active) begin
                    settle_active = 1'b1;
                    settle_t0     = now;
                end
                span_ms = now - settle_t0;
                if (span_ms >= HOLD_STABLE_MS) begin
                    cur_phase     = PH_HOLD;
                    settle_active = 1'b0;
                end
            end else begin
                settle_active = 1'b0;
            end
        end else if (cur_phase == PH_HOLD) begin
            if (t < (sp - 2 * db) * 16) begin
                if (!droop_active) begin
                    droop_active = 1'b1;
                    droop_t0     = now;
                end
                span_ms = now - droop_t0;
                if (span_ms >= RAMP_STABLE_MS) begin
                    cur_phase     = PH_RAMP;
                    droop_active  = 1'b0;
                    settle_active = 1'b0;
                end
            end else begin
                droop_active = 1'b0;
            end
        end else if (cur_phase == PH_COALBED) begin
            if (t > (sp - db) * 16) begin
                cur_phase     = PH_RAMP;
                settle_active = 1'b0;
                droop_active  = 1'b0;
            end
        end

        damper_state = (cur_phase != PH_IDLE);
        if (cur_phase == PH_BOOST || cur_phase == PH_RAMP) return int'(FAN_FULL);
        if (cur_phase == PH_HOLD) return hold_fan_demand(t);
        return 0;
    endfunction

    // Status reported for one item; updates the predictor state.
    function automatic burn_status_t predict_burn_step(logic [2:0] cmd, logic [31:0] now,
                                                        logic signed [15:0] temp);
        burn_status_t st;
        int           fan;
        fan = 0;
        case (cmd)
            CMD_SAMPLE: fan = sample_step(now, temp);
            CMD_INIT: begin
                cur_phase     = PH_BOOST;
                boost_active  = 1'b1;
                boost_t0      = now;
                settle_active = 1'b0;
                droop_active  = 1'b0;
                coal_active   = 1'b0;
                damper_state  = 1'b0;
            end
            CMD_START_BOOST: begin
                if (cur_phase != PH_SAFETY) begin
                    boost_active = 1'b1;
                    boost_t0     = now;
                    cur_phase    = PH_BOOST;
                end
            end
            CMD_FORCE_SAFETY: cur_phase = PH_SAFETY;
            CMD_FORCE_IDLE: cur_phase = PH_IDLE;
            default: ;
        endcase
        st.fan    = fan[6:0];
        st.damper = damper_state;
        st.phase  = cur_phase;
        st.boost  = boost_active;
        return st;
    endfunction

    // Writes all seven registers, one per clock, and mirrors them in the predictor.
    task automatic apply_cfg(input int v_sp, input int v_db, input int v_boost,
                             input int v_flue, input int v_coal, input int v_floor,
                             input int v_ceil);
        logic [CFG_ADDR_W-1:0] idx [7];
        int                    val [7];
        idx = '{REG_EXHAUST_SETPOINT, REG_DEADBAND, REG_BOOST_SECONDS, REG_FLUE_LOW_LIMIT,
                REG_COALBED_MINUTES, REG_FAN_FLOOR, REG_FAN_CEILING};
        val = '{v_sp, v_db, v_boost, v_flue, v_coal, v_floor, v_ceil};
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i][CFG_DATA_W-1:0];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cfg_setpoint = v_sp;
        cfg_deadband = v_db;
        cfg_boost_s  = v_boost;
        cfg_flue     = v_flue;
        cfg_coal_min = v_coal;
        cfg_floor    = v_floor;
        cfg_ceiling  = v_ceil;
    endtask

    // Offers one item, waits for acceptance, and queues the status it must produce.
    task automatic send_item(input logic [2:0] cmd, input logic [31:0] now,
                             input logic [15:0] temp, input bit typed,
                             input burn_status_t typed_status);
        burn_status_t predicted;
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_now_ms       <= now;
        s_exhaust_temp <= temp;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_burn_step(cmd, now, temp);
        status_due.push_back(typed ? typed_status : predicted);
        items_in++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] now,
                           input logic [15:0] temp, input bit typed, input logic [6:0] fan,
                           input logic damper, input phase_t ph, input logic boost);
        stim_row_t row;
        row.cmd           = cmd;
        row.now           = now;
        row.temp          = temp;
        row.typed         = typed;
        row.status.fan    = fan;
        row.status.damper = damper;
        row.status.phase  = ph;
        row.status.boost  = boost;
        stim_rows.push_back(row);
    endtask

    // Input side: reset, directed rows, then random burn sessions per register setting.
    initial begin : stimulus
        int          gap;
        int          burst_left;
        int          pick;
        int          heat;
        int          t;
        logic [31:0] clock_ms;
        logic [31:0] now;
        logic [2:0]  cmd;

        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Setpoint 1600/16, band edge at 1440/16, flue limit 800/16, two-second boost.
        apply_cfg(100, 10, 2, 50, 1, 30, 60);

        add_row(CMD_SAMPLE, 32'd0, 16'h7FFF, 1, 7'd0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_RESERVED, 32'hFFFF_FFFF, 16'h8000, 1, 7'd0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_INIT, 32'd0, 16'd0, 1, 7'd0, 1'b0, PH_BOOST, 1'b1);
        add_row(CMD_SAMPLE, 32'd1000, 16'd1600, 1, 7'd100, 1'b1, PH_BOOST, 1'b1);
        add_row(CMD_SAMPLE, 32'd2000, 16'd1600, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd7000, 16'd1600, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd7100, 16'd1400, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd7200, 16'd1200, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd7300, 16'd1100, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd7400, 16'd700, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd10200, 16'd1000, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_FORCE_SAFETY, 32'd10300, 16'd0, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_START_BOOST, 32'd10400, 16'd0, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd10500, 16'd0, 1, 7'd0, 1'b0, PH_SAFETY, 1'b0);
        add_row(CMD_FORCE_IDLE, 32'd10600, 16'd0, 1, 7'd0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd10700, 16'h8000, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd70700, 16'h8000, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'd70800, 16'h7FFF, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_START_BOOST, 32'd70900, 16'd0, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_INIT, 32'hFFFF_F000, 16'd0, 1, 7'd0, 1'b0, PH_BOOST, 1'b1);
        add_row(CMD_SAMPLE, 32'h0000_0100, 16'd1600, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'h0000_1500, 16'd1600, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'h0000_1600, 16'd1504, 0, '0, 1'b0, PH_IDLE, 1'b0);
        add_row(CMD_SAMPLE, 32'h0000_1700, 16'd1520, 0, '0, 1'b0, PH_IDLE, 1'b0);

        foreach (stim_rows[i]) begin
            send_item(stim_rows[i].cmd, stim_rows[i].now, stim_rows[i].temp,
                      stim_rows[i].typed, stim_rows[i].status);
            pause_sender($urandom_range(0, 2));
        end

        burst_left = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // Registers change only with the block drained.
            pause_sender(1);
            while (status_due.size() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
            case (p)
                0: apply_cfg(0, 0, 0, 0, 0, 0, 0);
                1: apply_cfg(1500, 200, 32767, 1500, 32767, 100, 100);
                2: apply_cfg(100, 10, 2, 50, 1, 30, 60);
                3: apply_cfg(800, 40, 1, 700, 0, 20, 90);
                4: apply_cfg(600, 25, 3, 200, 2, 90, 60);
                5: apply_cfg(1200, 5, 0, 1300, 1, 0, 100);
                default: apply_cfg($urandom_range(0, 1500), $urandom_range(0, 200),
                                   $urandom_range(0, 5), $urandom_range(0, 1500),
                                   $urandom_range(0, 3), $urandom_range(0, 100),
                                   $urandom_range(0, 100));
            endcase
            // One session runs across the 32-bit wrap of the millisecond clock.
            clock_ms = (p == 3) ? 32'hFFFF_0000 : $urandom;
            heat     = cfg_setpoint * 16;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Mostly samples; each session opens with an init.
                pick = $urandom_range(0, 99);
                if (n == 0 || (pick >= 84 && pick < 89)) cmd = CMD_INIT;
                else if (pick < 84) cmd = CMD_SAMPLE;
                else if (pick < 92) cmd = CMD_START_BOOST;
                else if (pick < 94) cmd = CMD_FORCE_SAFETY;
                else if (pick < 96) cmd = CMD_FORCE_IDLE;
                else cmd = 3'($urandom_range(int'(CMD_FORCE_IDLE) + 1, int'(CMD_RESERVED)));

                // Time mostly creeps forward, sometimes jumps, rarely is garbage.
                pick = $urandom_range(0, 99);
                if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 1500);
                else if (pick < 97) clock_ms = clock_ms + $urandom_range(0, 400000);
                now = (pick >= 97) ? $urandom : clock_ms;

                // Temperature drifts around a level that now and then moves.
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        heat = cfg_setpoint * 16 + 200 - int'($urandom_range(0, 1300));
                    else if (pick < 75)
                        heat = cfg_flue * 16 + int'($urandom_range(0, 80)) - 40;
                    else
                        heat = (cfg_setpoint - (pick < 88 ? 1 : 2) * cfg_deadband) * 16
                               + int'($urandom_range(0, 32)) - 16;
                end else begin
                    heat = heat + int'($urandom_range(0, 48)) - 24;
                end
                t = ($urandom_range(0, 99) < 5) ? int'($urandom_range(0, 65535)) : heat;

                send_item(cmd, now, t[15:0], 1'b0, '0);

                // Bursts of back-to-back items separated by short gaps.
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap        = $urandom_range(1, 10);
                end else begin
                    burst_left--;
                    gap = 0;
                end
                pause_sender(gap);
            end
        end

        pause_sender(1);
        while (status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("burn_phase_controller_test OK");
        end else begin
            $display("burn_phase_controller_test NOT OK");
        end
        $finish;
    end

    // Result side back-pressure: runs of always-ready, random and mostly-stalled
    // cycles, plus one long hold so the output register fills and stalls the input.
    initial begin : result_sink
        int mode;
        int span;
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && items_in >= LONG_HOLD_AFTER) begin
                held = 1'b1;
                repeat (LONG_HOLD_CYCLES) begin
                    @(posedge aclk);
                    m_ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result item against the oldest queued status.
    always @(posedge aclk) begin : check_status
        burn_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result item: fan %0d damper %0b phase %0d boost %0b",
                             m_fan_percent, m_damper_open, m_phase, m_boost_on);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                if (m_fan_percent !== want.fan || m_damper_open !== want.damper ||
                    m_phase !== want.phase || m_boost_on !== want.boost) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("mismatch at %0t (expected/actual):", $realtime);
                        $display("    fan %0d/%0d damper %0b/%0b phase %0d/%0d boost %0b/%0b",
                                 want.fan, m_fan_percent, want.damper, m_damper_open,
                                 want.phase, m_phase, want.boost, m_boost_on);
                    end
                    mismatches++;
                end
            end
        end
    end

endmodule
